// ===== rtl/tct_pkg.sv =====
// Package for the TCP connection tracker: item structs, state codes and flag masks.
// No dependencies; used by every module in rtl.
package tct_pkg;

   typedef enum logic [3:0] {
      ST_CLOSED    = 4'd0,
      ST_LISTEN    = 4'd1,
      ST_SYN_SENT  = 4'd2,
      ST_SYN_RCVD  = 4'd3,
      ST_ESTAB     = 4'd4,
      ST_FIN_WAIT1 = 4'd5,
      ST_FIN_WAIT2 = 4'd6,
      ST_CLOSE_WAIT = 4'd7,
      ST_CLOSING   = 4'd8,
      ST_LAST_ACK  = 4'd9,
      ST_TIME_WAIT = 4'd10
   } conn_state_type;

   localparam logic [1:0] ACT_SEGMENT = 2'd0;
   localparam logic [1:0] ACT_SET     = 2'd1;
   localparam logic [1:0] ACT_FREE    = 2'd2;

   localparam int unsigned FL_FIN_BIT = 0;
   localparam int unsigned FL_SYN_BIT = 1;
   localparam int unsigned FL_ACK_BIT = 4;
   localparam logic [7:0]  FL_ACK     = 8'h10;
   localparam logic [7:0]  FL_SYN_ACK = 8'h12;
   localparam logic [31:0] ISS_RESET  = 32'd1000;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  slot;
      logic [3:0]  new_state;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [7:0]  tcp_flags;
      logic [15:0] payload_len;
   } req_type;

   typedef struct packed {
      logic        matched;
      logic [3:0]  slot_out;
      logic [3:0]  conn_state;
      logic        send_reply;
      logic [7:0]  reply_flags;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic [15:0] reply_src_port;
      logic [15:0] reply_dst_port;
      logic [31:0] reply_dst_ip;
      logic        data_accepted;
   } rsp_type;

endpackage

// ===== rtl/tct_front.sv =====
// Front end of the connection tracker: accepts items and queues them for the back end.
// Depends on tct_pkg.
module tct_front
   import tct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   input  logic    pop,
   output logic    q_valid,
   output req_type q_item
);

   // Two-entry queue; busy when full.
   req_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (pop && q_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= req;
      end
   end

endmodule

// ===== rtl/tct_back.sv =====
// Back end: slot match over cycles, state machine update and result strobe.
// Depends on tct_pkg.
module tct_back
   import tct_pkg::*;
#(
   parameter int unsigned SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  req_type q_item,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EXEC} phase_type;

   phase_type      phase_ff;
   logic [SLOTS-1:0] used_ff;
   logic [3:0]     state_ff [SLOTS];
   logic [15:0]    lport_ff [SLOTS];
   logic [15:0]    rport_ff [SLOTS];
   logic [31:0]    raddr_ff [SLOTS];
   logic [31:0]    rnxt_ff  [SLOTS];
   logic [31:0]    snxt_ff  [SLOTS];
   logic [31:0]    suna_ff  [SLOTS];
   logic [31:0]    irs_ff   [SLOTS];
   logic [31:0]    iss_ff;
   req_type        it_ff;
   logic [SLOTS-1:0] hit_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic [SLOTS-1:0] hit_in;
   logic             found;
   logic [IW-1:0]    s;
   logic             slot_ok;
   logic [IW-1:0]    ws;

   // Per-slot compare is registered; the priority pick follows in the next cycle.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         hit_in[i] = used_ff[i] && lport_ff[i] == it_ff.dst_port
            && (rport_ff[i] == 16'd0 || rport_ff[i] == it_ff.src_port)
            && (raddr_ff[i] == 32'd0 || raddr_ff[i] == it_ff.src_ip);
      end
      found = 1'b0;
      s     = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            found = 1'b1;
            s     = IW'(i);
         end
      end
   end

   assign slot_ok = ({28'd0, it_ff.slot} < 32'(SLOTS));
   assign ws      = IW'(it_ff.slot);
   assign pop     = (phase_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      logic [7:0]  fl;
      logic [3:0]  st;
      logic [31:0] sn;
      logic [31:0] rn;
      logic [7:0]  rf;
      logic        rep;
      logic        acc;
      rsp_type     r;
      fl  = it_ff.tcp_flags;
      st  = state_ff[s];
      sn  = snxt_ff[s];
      rn  = rnxt_ff[s];
      rf  = 8'd0;
      rep = 1'b0;
      acc = 1'b0;
      r   = '0;
      if (reset) begin
         phase_ff     <= S_IDLE;
         used_ff      <= '0;
         for (int i = 0; i < SLOTS; i++) state_ff[i] <= ST_CLOSED;
         iss_ff       <= ISS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (phase_ff)
            S_IDLE: begin
               if (q_valid) begin
                  it_ff    <= q_item;
                  phase_ff <= S_MATCH;
               end
            end
            S_MATCH: begin
               hit_ff   <= hit_in;
               phase_ff <= S_EXEC;
            end
            S_EXEC: begin
               phase_ff <= S_IDLE;
               if (it_ff.action == ACT_SEGMENT && found) begin
                  logic [15:0] rp;
                  logic [31:0] ra;
                  rp = rport_ff[s];
                  ra = raddr_ff[s];
                  case (st)
                     ST_LISTEN: begin
                        if (fl[FL_SYN_BIT]) begin
                           ra = it_ff.src_ip;
                           rp = it_ff.src_port;
                           rn = it_ff.seq_num + 32'd1;
                           irs_ff[s] <= it_ff.seq_num;
                           sn = iss_ff;
                           iss_ff <= iss_ff + 32'd1;
                           st = ST_SYN_RCVD;
                           rep = 1'b1;
                           rf = FL_SYN_ACK;
                        end
                     end
                     ST_SYN_SENT: begin
                        if (fl[FL_SYN_BIT]) begin
                           rn = it_ff.seq_num + 32'd1;
                           irs_ff[s] <= it_ff.seq_num;
                           rep = 1'b1;
                           rf = FL_ACK;
                           if (fl[FL_ACK_BIT]) begin
                              suna_ff[s] <= it_ff.ack_num;
                              st = ST_ESTAB;
                           end else begin
                              st = ST_SYN_RCVD;
                           end
                        end
                     end
                     ST_SYN_RCVD: begin
                        if (fl[FL_ACK_BIT]) begin
                           suna_ff[s] <= it_ff.ack_num;
                           st = ST_ESTAB;
                        end
                     end
                     ST_ESTAB: begin
                        if (fl[FL_FIN_BIT]) begin
                           rn = it_ff.seq_num + 32'd1;
                           st = ST_CLOSE_WAIT;
                           rep = 1'b1;
                           rf = FL_ACK;
                        end else if (fl[FL_ACK_BIT]) begin
                           suna_ff[s] <= it_ff.ack_num;
                           if (it_ff.payload_len != 16'd0 && it_ff.seq_num == rn) begin
                              rn = rn + {16'd0, it_ff.payload_len};
                              acc = 1'b1;
                              rep = 1'b1;
                              rf = FL_ACK;
                           end
                        end
                     end
                     ST_FIN_WAIT1: begin
                        if (fl[FL_FIN_BIT]) begin
                           rn = it_ff.seq_num + 32'd1;
                           rep = 1'b1;
                           rf = FL_ACK;
                           st = fl[FL_ACK_BIT] ? ST_TIME_WAIT : ST_CLOSING;
                        end else if (fl[FL_ACK_BIT]) begin
                           st = ST_FIN_WAIT2;
                        end
                     end
                     ST_FIN_WAIT2: begin
                        if (fl[FL_FIN_BIT]) begin
                           rn = it_ff.seq_num + 32'd1;
                           rep = 1'b1;
                           rf = FL_ACK;
                           st = ST_TIME_WAIT;
                        end
                     end
                     ST_CLOSING: begin
                        if (fl[FL_ACK_BIT]) st = ST_TIME_WAIT;
                     end
                     ST_LAST_ACK: begin
                        if (fl[FL_ACK_BIT]) begin
                           st = ST_CLOSED;
                           used_ff[s] <= 1'b0;
                        end
                     end
                     ST_TIME_WAIT: begin
                        st = ST_CLOSED;
                        used_ff[s] <= 1'b0;
                     end
                     default: begin
                     end
                  endcase
                  r.matched        = 1'b1;
                  r.slot_out       = 4'(s);
                  r.conn_state     = st;
                  r.send_reply     = rep;
                  r.reply_flags    = rf;
                  r.reply_seq      = rep ? sn : 32'd0;
                  r.reply_ack      = rep ? rn : 32'd0;
                  r.reply_src_port = lport_ff[s];
                  r.reply_dst_port = rp;
                  r.reply_dst_ip   = ra;
                  r.data_accepted  = acc;
                  // A SYN in the reply consumes one sequence number.
                  snxt_ff[s]  <= (rep && rf == FL_SYN_ACK) ? sn + 32'd1 : sn;
                  rnxt_ff[s]  <= rn;
                  rport_ff[s] <= rp;
                  raddr_ff[s] <= ra;
                  state_ff[s] <= st;
               end else if (it_ff.action == ACT_SET) begin
                  r.slot_out = it_ff.slot;
                  if (slot_ok) begin
                     logic [3:0] ns;
                     ns = (it_ff.new_state > 4'(ST_TIME_WAIT)) ? 4'(ST_CLOSED)
                                                              : it_ff.new_state;
                     used_ff[ws]  <= 1'b1;
                     state_ff[ws] <= ns;
                     raddr_ff[ws] <= it_ff.src_ip;
                     rport_ff[ws] <= it_ff.src_port;
                     lport_ff[ws] <= it_ff.dst_port;
                     snxt_ff[ws]  <= it_ff.seq_num;
                     suna_ff[ws]  <= it_ff.seq_num;
                     rnxt_ff[ws]  <= 32'd0;
                     irs_ff[ws]   <= 32'd0;
                     r.conn_state = ns;
                  end
               end else if (it_ff.action == ACT_FREE) begin
                  r.slot_out = it_ff.slot;
                  if (slot_ok) begin
                     used_ff[ws]  <= 1'b0;
                     state_ff[ws] <= ST_CLOSED;
                  end
               end
               rsp_ff       <= r;
               rsp_valid_ff <= 1'b1;
            end
            default: phase_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/tcp_connection_tracker_top.sv =====
// Top level of the TCP connection tracker: front queue and back-end slot engine.
// Depends on tct_pkg, tct_front and tct_back.
//
// Each item gives one result, strobed by rsp_valid for one cycle; the back end takes the
// item from the queue into a register in its idle step, registers the slot compare in its
// match step and registers the result and the strobe in its execute step. It takes no new
// item from the queue until the execute step is done, so items are handled one at a time.
// A two-entry queue in front lets start be taken while the back end works; busy rises
// when it is full. The receiver cannot stall results.
module tcp_connection_tracker_top
   import tct_pkg::*;
#(
   parameter int unsigned SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   logic    pop;
   logic    q_valid;
   req_type q_item;

   tct_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .req     (req_item),
      .pop     (pop),
      .q_valid (q_valid),
      .q_item  (q_item)
   );

   tct_back #(.SLOTS(SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_item)
   );

endmodule
